[rtl/core/jvr_pkg.sv]
// Shared types, codes and tables of the JSON validator and re-indenter.
`default_nettype none

package jvr_pkg;

   localparam int LEVEL_W = 4;
   localparam int POS_W   = 24;
   localparam int CODE_W  = 5;

   localparam logic [1:0] MODE_TWO  = 2'd0;
   localparam logic [1:0] MODE_FOUR = 2'd1;
   localparam logic [1:0] MODE_MIN  = 2'd2;

   localparam logic [CODE_W-1:0] ST_VALID      = 5'd0;
   localparam logic [CODE_W-1:0] ST_TRAILING   = 5'd1;
   localparam logic [CODE_W-1:0] ST_EXP_VALUE  = 5'd2;
   localparam logic [CODE_W-1:0] ST_EXP_COLON  = 5'd3;
   localparam logic [CODE_W-1:0] ST_EXP_OBJSEP = 5'd4;
   localparam logic [CODE_W-1:0] ST_EXP_ARRSEP = 5'd5;
   localparam logic [CODE_W-1:0] ST_EXP_STRING = 5'd6;
   localparam logic [CODE_W-1:0] ST_CTRL_CHAR  = 5'd7;
   localparam logic [CODE_W-1:0] ST_OPEN_ESC   = 5'd8;
   localparam logic [CODE_W-1:0] ST_BAD_UESC   = 5'd9;
   localparam logic [CODE_W-1:0] ST_BAD_ESC    = 5'd10;
   localparam logic [CODE_W-1:0] ST_OPEN_STR   = 5'd11;
   localparam logic [CODE_W-1:0] ST_BAD_NUM    = 5'd12;
   localparam logic [CODE_W-1:0] ST_BAD_FRAC   = 5'd13;
   localparam logic [CODE_W-1:0] ST_BAD_EXP    = 5'd14;
   localparam logic [CODE_W-1:0] ST_BAD_LIT    = 5'd15;
   localparam logic [CODE_W-1:0] ST_TOO_DEEP   = 5'd16;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // One command from the parser to the output expander.
   typedef struct packed {
      logic               is_status;
      logic [7:0]         data;
      logic               nl_before;
      logic               nl_after;
      logic               space_after;
      logic               wide;
      logic [LEVEL_W-1:0] levels;
      logic [CODE_W-1:0]  status;
      logic [POS_W-1:0]   pos;
   } cmd_type;

   // Literal spelling: kind 0 true, 1 false, 2 null.
   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (kind)
         2'd1: begin
            case (idx)
               3'd0: c = "f";
               3'd1: c = "a";
               3'd2: c = "l";
               3'd3: c = "s";
               3'd4: c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd2: begin
            case (idx)
               3'd0: c = "n";
               3'd1: c = "u";
               3'd2: c = "l";
               3'd3: c = "l";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0: c = "t";
               3'd1: c = "r";
               3'd2: c = "u";
               3'd3: c = "e";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      return (kind == 2'd1) ? 3'd5 : 3'd4;
   endfunction

endpackage

`default_nettype wire

[rtl/core/json_validate_reindent.sv]
// Top level of the streaming JSON validator and re-indenter.
//
// Input channel: one word per text byte (req_op low) or an end-of-document
// mark (req_op high). A word is taken when req_push is high and req_full is
// low. The parser checks one byte per cycle, so text streams in back to back
// as long as the four-entry command queue behind the parser has room.
// Result channel: the oldest result word sits on the rsp_ ports while
// rsp_empty is low and leaves when rsp_pop is high. Each byte word yields
// zero or more output bytes; a newline with indentation is produced one byte
// per cycle while the receiver takes results, so a byte that opens a line
// yields up to two plus 4 times depth result words (62 at most). The end
// mark yields one status word carrying the first error and its position, or
// valid and the total length. Commands pass the queue, then the output
// register. When the receiver stalls the output register holds, the queue
// fills and req_full rises; nothing is dropped. csr_write sets the indent
// mode (two spaces, four spaces or minified) and is meant for idle periods.
// Reset clears the parser, the queue and the output register, and sets
// two-space mode. After an error, bytes are discarded until the end mark.
`default_nettype none

module json_validate_reindent
   import jvr_pkg::*;
#(
   parameter int MAX_DEPTH     = 15,
   parameter int QUEUE_DEPTH   = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire logic              req_op,
   input  wire logic [7:0]        req_in_byte,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      logic [7:0]        rsp_out_byte,
   output      logic              rsp_has_byte,
   output      logic [CODE_W-1:0] rsp_status,
   output      logic [POS_W-1:0]  rsp_error_position,
   output      logic              rsp_run_end,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_data
);

   logic [1:0] mode_ff;
   logic       accept, cmd_valid, q_valid, q_pop;
   cmd_type    cmd, q_head;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_TWO;
      else if (csr_write) mode_ff <= csr_data;
   end

   assign accept = req_push && !req_full;

   // The parser updates its state on every accepted word.
   jvr_front #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .indent_mode(mode_ff),
      .in_valid   (accept),
      .in_op      (req_op),
      .in_byte    (req_in_byte),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   jvr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_data(cmd),
      .full     (req_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   jvr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_status        (rsp_status),
      .rsp_error_position(rsp_error_position),
      .rsp_run_end       (rsp_run_end)
   );

   // A status word always closes its run.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_has_byte |-> rsp_run_end)
      else $error("status word without run end");

   // Byte words never carry a status code.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_has_byte |-> rsp_status == ST_VALID)
      else $error("byte word carries a status");

   // The queue is only popped while it holds a command.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");

   // A waiting result that is not taken holds on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte))
      else $error("stalled result changed");

endmodule

`default_nettype wire

[rtl/core/jvr_front.sv]
// Parser front end: checks each byte against the grammar and issues output commands.
`default_nettype none

module jvr_front
   import jvr_pkg::*;
#(
   parameter int MAX_DEPTH = 15
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] indent_mode,
   input  wire logic       in_valid,
   input  wire logic       in_op,
   input  wire logic [7:0] in_byte,
   output      logic       cmd_valid,
   output      cmd_type    cmd
);

   localparam int LVL_W         = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W         = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int POSITION_BITS = POS_W;

   typedef enum logic [4:0] {
      PH_VALUE, PH_KEY, PH_COLON, PH_AFTER, PH_STR, PH_ESC, PH_HEX,
      PH_NSIGN, PH_NZERO, PH_NINT, PH_NDOT, PH_NFRAC, PH_NEXP, PH_NESIGN,
      PH_NEDIG, PH_LIT, PH_ERR
   } phase_type;

   phase_type                phase_ff, phase_in, eff_ph;
   logic [MAX_DEPTH-1:0]     stack_ff, stack_in;
   logic [LVL_W-1:0]         level_ff, level_in, level_m1;
   logic                     open_ff, open_in;
   logic [2:0]               tp_ff, tp_in;
   logic [1:0]               lk_ff, lk_in;
   logic [POSITION_BITS-1:0] count_ff, count_in, count_next, lit_pos;
   logic [CODE_W-1:0]        err_ff, err_in;

   logic pretty, top_obj, is_ws, is_digit, is_hex, num_cont;
   logic emit, fail, nl_before, nl_after, space_after;
   logic [LVL_W-1:0]         nl_levels;
   logic [CODE_W-1:0]        fcode, end_code;
   logic [POSITION_BITS-1:0] fpos, end_pos;
   logic [1:0]               lkk;
   logic                     is_open;

   assign pretty   = (indent_mode != MODE_MIN);
   assign level_m1 = level_ff - 1'b1;
   assign top_obj  = (level_ff == '0) ? 1'b0 : stack_ff[level_m1[IDX_W-1:0]];
   assign is_ws    = (in_byte == 8'h20) || (in_byte == 8'h09) ||
                     (in_byte == 8'h0A) || (in_byte == 8'h0D);
   assign is_digit = (in_byte >= "0") && (in_byte <= "9");
   assign is_hex   = is_digit || ((in_byte >= "a") && (in_byte <= "f")) ||
                     ((in_byte >= "A") && (in_byte <= "F"));
   assign count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign lit_pos    = (count_ff >= POSITION_BITS'(tp_ff)) ?
                       count_ff - POSITION_BITS'(tp_ff) : '0;
   assign lkk        = (lk_ff == 2'd3) ? 2'd0 : lk_ff;
   assign is_open    = (in_byte == "{") || (in_byte == "[");

   // A number ends on any byte that cannot extend it; that byte is then
   // parsed as if it followed a complete value.
   always_comb begin
      num_cont = 1'b1;
      case (phase_ff)
         PH_NZERO, PH_NINT, PH_NFRAC:
            num_cont = (is_digit && phase_ff != PH_NZERO) ||
                       (in_byte == "." && phase_ff != PH_NFRAC) ||
                       (in_byte == "e") || (in_byte == "E");
         PH_NEDIG: num_cont = is_digit;
         default: num_cont = 1'b1;
      endcase
      eff_ph = num_cont ? phase_ff : PH_AFTER;
   end

   always_comb begin
      phase_in    = phase_ff;
      stack_in    = stack_ff;
      level_in    = level_ff;
      open_in     = open_ff;
      tp_in       = tp_ff;
      lk_in       = lk_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      emit        = 1'b0;
      fail        = 1'b0;
      nl_before   = 1'b0;
      nl_after    = 1'b0;
      space_after = 1'b0;
      nl_levels   = level_ff;
      fcode       = ST_VALID;
      fpos        = count_ff;
      end_code    = ST_VALID;
      end_pos     = count_ff;

      unique case (phase_ff)
         PH_VALUE:  end_code = ST_EXP_VALUE;
         PH_KEY:    end_code = ST_EXP_STRING;
         PH_COLON:  end_code = ST_EXP_COLON;
         PH_STR:    end_code = ST_OPEN_STR;
         PH_ESC:    end_code = ST_OPEN_ESC;
         PH_HEX:    end_code = ST_BAD_UESC;
         PH_NSIGN:  end_code = ST_BAD_NUM;
         PH_NDOT:   end_code = ST_BAD_FRAC;
         PH_NEXP, PH_NESIGN: end_code = ST_BAD_EXP;
         PH_LIT: begin
            end_code = ST_BAD_LIT;
            end_pos  = lit_pos;
         end
         PH_ERR:    end_code = err_ff;
         default:   end_code = (level_ff == '0) ? ST_VALID :
                               (top_obj ? ST_EXP_OBJSEP : ST_EXP_ARRSEP);
      endcase

      if (in_valid && !in_op && phase_ff != PH_ERR) begin
         unique case (eff_ph)
            PH_VALUE, PH_KEY: begin
               if (!is_ws) begin
                  if (open_ff && level_ff != '0 &&
                      in_byte == (top_obj ? 8'h7D : 8'h5D)) begin
                     open_in  = 1'b0;
                     emit     = 1'b1;
                     level_in = level_m1;
                     phase_in = PH_AFTER;
                  end else begin
                     open_in   = 1'b0;
                     nl_before = open_ff && pretty;
                     if (eff_ph == PH_KEY) begin
                        if (in_byte != 8'h22) begin
                           fail = 1'b1; fcode = ST_EXP_STRING;
                        end else begin
                           emit = 1'b1; lk_in = 2'd1; phase_in = PH_STR;
                        end
                     end else if (is_open) begin
                        if (level_ff >= LVL_W'(MAX_DEPTH)) begin
                           fail = 1'b1; fcode = ST_TOO_DEEP;
                        end else begin
                           emit     = 1'b1;
                           stack_in[level_ff[IDX_W-1:0]] = (in_byte == "{");
                           level_in = level_ff + 1'b1;
                           open_in  = 1'b1;
                           phase_in = (in_byte == "{") ? PH_KEY : PH_VALUE;
                        end
                     end else if (in_byte == 8'h22) begin
                        emit = 1'b1; lk_in = 2'd0; phase_in = PH_STR;
                     end else if (in_byte == "t" || in_byte == "f" || in_byte == "n") begin
                        emit     = 1'b1;
                        lk_in    = (in_byte == "t") ? 2'd0 : (in_byte == "f") ? 2'd1 : 2'd2;
                        tp_in    = 3'd1;
                        phase_in = PH_LIT;
                     end else if (in_byte == "-") begin
                        emit = 1'b1; phase_in = PH_NSIGN;
                     end else if (in_byte == "0") begin
                        emit = 1'b1; phase_in = PH_NZERO;
                     end else if (is_digit) begin
                        emit = 1'b1; phase_in = PH_NINT;
                     end else begin
                        fail = 1'b1; fcode = ST_EXP_VALUE;
                     end
                  end
               end
            end
            PH_COLON: begin
               if (!is_ws) begin
                  if (in_byte != ":") begin
                     fail = 1'b1; fcode = ST_EXP_COLON;
                  end else begin
                     emit = 1'b1; space_after = pretty; phase_in = PH_VALUE;
                  end
               end
            end
            PH_AFTER: begin
               phase_in = PH_AFTER;
               if (!is_ws) begin
                  if (level_ff == '0) begin
                     fail = 1'b1; fcode = ST_TRAILING;
                  end else if (in_byte == ",") begin
                     emit     = 1'b1;
                     nl_after = pretty;
                     phase_in = top_obj ? PH_KEY : PH_VALUE;
                  end else if (in_byte == (top_obj ? 8'h7D : 8'h5D)) begin
                     emit      = 1'b1;
                     nl_before = pretty;
                     nl_levels = level_m1;
                     level_in  = level_m1;
                  end else begin
                     fail = 1'b1; fcode = top_obj ? ST_EXP_OBJSEP : ST_EXP_ARRSEP;
                  end
               end
            end
            PH_STR: begin
               if (in_byte == 8'h22) begin
                  emit = 1'b1; phase_in = (lk_ff == 2'd1) ? PH_COLON : PH_AFTER;
               end else if (in_byte < 8'h20) begin
                  fail = 1'b1; fcode = ST_CTRL_CHAR; fpos = count_next;
               end else begin
                  emit = 1'b1;
                  if (in_byte == 8'h5C) phase_in = PH_ESC;
               end
            end
            PH_ESC: begin
               if (in_byte == 8'h22 || in_byte == 8'h5C || in_byte == "/" ||
                   in_byte == "b" || in_byte == "f" || in_byte == "n" ||
                   in_byte == "r" || in_byte == "t") begin
                  emit = 1'b1; phase_in = PH_STR;
               end else if (in_byte == "u") begin
                  emit = 1'b1; tp_in = 3'd0; phase_in = PH_HEX;
               end else begin
                  fail = 1'b1; fcode = ST_BAD_ESC; fpos = count_next;
               end
            end
            PH_HEX: begin
               if (!is_hex) begin
                  fail = 1'b1; fcode = ST_BAD_UESC;
               end else begin
                  emit  = 1'b1;
                  tp_in = tp_ff + 1'b1;
                  if (tp_ff >= 3'd3) phase_in = PH_STR;
               end
            end
            PH_NSIGN: begin
               if (in_byte == "0") begin
                  emit = 1'b1; phase_in = PH_NZERO;
               end else if (is_digit) begin
                  emit = 1'b1; phase_in = PH_NINT;
               end else begin
                  fail = 1'b1; fcode = ST_BAD_NUM;
               end
            end
            PH_NZERO, PH_NINT, PH_NFRAC: begin
               emit = 1'b1;
               if (is_digit && phase_ff != PH_NZERO) phase_in = phase_ff;
               else if (in_byte == ".") phase_in = PH_NDOT;
               else phase_in = PH_NEXP;
            end
            PH_NDOT: begin
               if (!is_digit) begin
                  fail = 1'b1; fcode = ST_BAD_FRAC;
               end else begin
                  emit = 1'b1; phase_in = PH_NFRAC;
               end
            end
            PH_NEXP: begin
               if (in_byte == "+" || in_byte == "-") begin
                  emit = 1'b1; phase_in = PH_NESIGN;
               end else if (is_digit) begin
                  emit = 1'b1; phase_in = PH_NEDIG;
               end else begin
                  fail = 1'b1; fcode = ST_BAD_EXP;
               end
            end
            PH_NESIGN: begin
               if (!is_digit) begin
                  fail = 1'b1; fcode = ST_BAD_EXP;
               end else begin
                  emit = 1'b1; phase_in = PH_NEDIG;
               end
            end
            PH_NEDIG: emit = 1'b1;
            PH_LIT: begin
               if (tp_ff < lit_len(lkk) && in_byte == lit_char(lkk, tp_ff)) begin
                  emit  = 1'b1;
                  tp_in = tp_ff + 1'b1;
                  if (tp_ff + 3'd1 >= lit_len(lkk)) phase_in = PH_AFTER;
               end else begin
                  fail = 1'b1; fcode = ST_BAD_LIT; fpos = lit_pos;
               end
            end
            default: emit = 1'b0;
         endcase

         if (fail) begin
            emit     = 1'b0;
            phase_in = PH_ERR;
            err_in   = fcode;
            count_in = fpos;
         end else begin
            count_in = count_next;
         end
      end

      if (in_valid && in_op) begin
         phase_in = PH_VALUE;
         level_in = '0;
         open_in  = 1'b0;
         tp_in    = 3'd0;
         lk_in    = 2'd0;
         count_in = '0;
         err_in   = ST_VALID;
      end
   end

   always_comb begin
      cmd_valid       = in_valid && (in_op || emit);
      cmd.is_status   = in_op;
      cmd.data        = in_op ? 8'h00 : in_byte;
      cmd.nl_before   = !in_op && nl_before;
      cmd.nl_after    = !in_op && nl_after;
      cmd.space_after = !in_op && space_after;
      cmd.wide        = (indent_mode == MODE_FOUR);
      cmd.levels      = LEVEL_W'(nl_levels);
      cmd.status      = in_op ? end_code : ST_VALID;
      cmd.pos         = in_op ? POS_W'(end_pos) : '0;
   end

   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
      if (reset) begin
         phase_ff <= PH_VALUE;
         level_ff <= '0;
         open_ff  <= 1'b0;
         tp_ff    <= 3'd0;
         lk_ff    <= 2'd0;
         count_ff <= '0;
         err_ff   <= ST_VALID;
      end else begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         open_ff  <= open_in;
         tp_ff    <= tp_in;
         lk_ff    <= lk_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/jvr_queue.sv]
// Small command queue between the parser and the output expander.
`default_nettype none

module jvr_queue
   import jvr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   output      logic    full,
   input  wire logic    pop,
   output      logic    valid,
   output      cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/jvr_back.sv]
// Output expander: turns commands into newline, indent, byte, space and status words.
`default_nettype none

module jvr_back
   import jvr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  cmd_type                 q_head,
   output      logic               q_pop,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      logic [7:0]         rsp_out_byte,
   output      logic               rsp_has_byte,
   output      logic [CODE_W-1:0]  rsp_status,
   output      logic [POS_W-1:0]   rsp_error_position,
   output      logic               rsp_run_end
);

   typedef enum logic [2:0] {
      S_LEAD_NL = 3'd0, S_LEAD_SP = 3'd1, S_MAIN = 3'd2,
      S_COLON_SP = 3'd3, S_TAIL_NL = 3'd4, S_TAIL_SP = 3'd5
   } stage_type;

   stage_type         stage_ff, stage_in, cur, nxt;
   logic              busy_ff, busy_in;
   logic [5:0]        sp_ff, sp_in, cur_sp, nsp;
   logic [5:0]        en;
   logic              can_emit, last, found, stay;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              has_ff, has_in, end_ff, end_in;
   logic [CODE_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   assign nsp = q_head.wide ? {q_head.levels, 2'b00} : {1'b0, q_head.levels, 1'b0};
   assign en  = {q_head.nl_after && nsp != '0, q_head.nl_after, q_head.space_after,
                 1'b1, q_head.nl_before && nsp != '0, q_head.nl_before};
   assign cur    = busy_ff ? stage_ff : (q_head.nl_before ? S_LEAD_NL : S_MAIN);
   assign cur_sp = busy_ff ? sp_ff : 6'd0;
   assign stay   = (cur == S_LEAD_SP || cur == S_TAIL_SP) && (cur_sp + 6'd1 < nsp);
   assign can_emit = !valid_ff || rsp_pop;

   always_comb begin
      found = 1'b0;
      nxt   = S_MAIN;
      for (int i = 5; i >= 0; i--) begin
         if (en[i] && 3'(i) > cur) begin
            found = 1'b1;
            nxt   = stage_type'(3'(i));
         end
      end
      last = !stay && !found;
   end

   always_comb begin
      stage_in  = stage_ff;
      busy_in   = busy_ff;
      sp_in     = sp_ff;
      valid_in  = valid_ff && !rsp_pop;
      byte_in   = byte_ff;
      has_in    = has_ff;
      end_in    = end_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      q_pop     = 1'b0;
      if (can_emit && q_valid) begin
         valid_in  = 1'b1;
         has_in    = !q_head.is_status;
         status_in = q_head.status;
         pos_in    = q_head.pos;
         end_in    = last;
         case (cur)
            S_LEAD_NL, S_TAIL_NL:   byte_in = CH_LF;
            S_LEAD_SP, S_TAIL_SP,
            S_COLON_SP:             byte_in = CH_SPACE;
            default:                byte_in = q_head.data;
         endcase
         if (stay) begin
            busy_in  = 1'b1;
            stage_in = cur;
            sp_in    = cur_sp + 6'd1;
         end else if (found) begin
            busy_in  = 1'b1;
            stage_in = nxt;
            sp_in    = 6'd0;
         end else begin
            busy_in = 1'b0;
            q_pop   = 1'b1;
         end
      end
   end

   assign rsp_empty          = !valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_has_byte       = has_ff;
   assign rsp_status         = status_ff;
   assign rsp_error_position = pos_ff;
   assign rsp_run_end        = end_ff;

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      has_ff    <= has_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      sp_ff     <= sp_in;
      if (reset) begin
         stage_ff <= S_MAIN;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

[tb/sv/json_validate_reindent_test.sv]
// Self-checking testbench of the streaming JSON validator and re-indenter.
module json_validate_reindent_test;
   import jvr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEVELS = 15;
   localparam int CNT_MAX    = (1 << POS_W) - 1;
   localparam int RUN_ITEMS  = 410;
   localparam int QUIET_TAIL = 60;
   localparam int DRAIN_WAIT = 12;
   localparam int CYCLE_CAP  = 2000000;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Parser phases of the predictor.
   typedef enum int {
      P_VALUE, P_KEY, P_COLON, P_AFTER, P_STR, P_ESC, P_HEX, P_NSIGN, P_NZERO,
      P_NINT, P_NDOT, P_NFRAC, P_NEXP, P_NESIGN, P_NEDIG, P_LIT, P_ERR
   } phase_t;

   // One result word as the block should deliver it.
   typedef struct {
      logic [7:0]        out_byte;
      logic              has_byte;
      logic [CODE_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic              run_end;
   } word_t;

   // One row of the directed table. Rows with typed set carry their status word.
   typedef struct {
      logic              op;
      logic [7:0]        text;
      bit                typed;
      logic [CODE_W-1:0] status;
      int                position;
   } row_t;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_op;
   logic [7:0]        req_in_byte;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [7:0]        rsp_out_byte;
   logic              rsp_has_byte;
   logic [CODE_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_error_position;
   logic              rsp_run_end;
   logic              csr_write;
   logic [1:0]        csr_data;

   json_validate_reindent DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_op(req_op), .req_in_byte(req_in_byte),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_out_byte(rsp_out_byte),
      .rsp_has_byte(rsp_has_byte), .rsp_status(rsp_status),
      .rsp_error_position(rsp_error_position), .rsp_run_end(rsp_run_end),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   // Words still owed by the block, oldest first.
   word_t pending_words[$];
   int    fail_count = 0;
   int    cycle_count = 0;
   bit    quiet = 0;

   // Shadow copy of the parser state and the indent mode.
   logic [1:0]       mode_q;
   phase_t           phase;
   bit               nest_obj[MAX_LEVELS];
   int               depth;
   bit               open_wait;
   int               tok_pos;
   int               lit_sel;
   int               text_len;
   logic [CODE_W-1:0] err_code;
   logic [7:0]       emitted[$];
   string            spell[3] = '{"true", "false", "null"};

   // Text of the current random document.
   logic [7:0] doc[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: the run must never get near this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      fail_count++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
   endtask

   // Appends one byte to the predicted output of the current word.
   function automatic void emit_byte(logic [7:0] c);
      emitted = {emitted, c};
   endfunction

   // Appends one byte to the document text.
   function automatic void doc_add(logic [7:0] c);
      doc = {doc, c};
   endfunction

   function automatic void clear_parser();
      phase = P_VALUE;
      foreach (nest_obj[i]) nest_obj[i] = 0;
      depth = 0;
      open_wait = 0;
      tok_pos = 0;
      lit_sel = 0;
      text_len = 0;
      err_code = ST_VALID;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit top_obj();
      return (depth == 0) ? 1'b0 : nest_obj[depth-1];
   endfunction

   // Newline plus indentation; nothing in minified mode.
   function automatic void break_line(int levels);
      if (mode_q == MODE_MIN) return;
      emit_byte(CH_LF);
      repeat (levels * ((mode_q == MODE_FOUR) ? 4 : 2)) emit_byte(CH_SPACE);
   endfunction

   function automatic bit trip(logic [CODE_W-1:0] code, int where);
      err_code = code;
      text_len = (where > CNT_MAX) ? CNT_MAX : where;
      phase = P_ERR;
      return 1'b0;
   endfunction

   // Runs one text byte through the grammar; a zero return means it failed.
   function automatic bit parse_byte(logic [7:0] c);
      int here;
      logic [7:0] closer;
      bit obj;
      here = text_len;
      forever begin
         case (phase)
            P_VALUE, P_KEY: begin
               if (is_blank(c)) return 1'b1;
               if (open_wait) begin
                  closer = top_obj() ? "}" : "]";
                  open_wait = 0;
                  if (c == closer && depth > 0) begin
                     emit_byte(c);
                     depth--;
                     phase = P_AFTER;
                     return 1'b1;
                  end
                  break_line(depth);
               end
               if (phase == P_KEY) begin
                  if (c != "\"") return trip(ST_EXP_STRING, here);
                  emit_byte(c);
                  lit_sel = 1;
                  phase = P_STR;
                  return 1'b1;
               end
               if (c == "{" || c == "[") begin
                  if (depth >= MAX_LEVELS) return trip(ST_TOO_DEEP, here);
                  emit_byte(c);
                  nest_obj[depth] = (c == "{");
                  depth++;
                  open_wait = 1;
                  phase = (c == "{") ? P_KEY : P_VALUE;
                  return 1'b1;
               end
               emit_byte(c);
               if (c == "\"") begin
                  lit_sel = 0;
                  phase = P_STR;
               end else if (c == "t" || c == "f" || c == "n") begin
                  lit_sel = (c == "t") ? 0 : (c == "f") ? 1 : 2;
                  tok_pos = 1;
                  phase = P_LIT;
               end else if (c == "-") phase = P_NSIGN;
               else if (c == "0") phase = P_NZERO;
               else if (is_num(c)) phase = P_NINT;
               else begin
                  void'(emitted.pop_back());
                  return trip(ST_EXP_VALUE, here);
               end
               return 1'b1;
            end
            P_COLON: begin
               if (is_blank(c)) return 1'b1;
               if (c != ":") return trip(ST_EXP_COLON, here);
               emit_byte(c);
               if (mode_q != MODE_MIN) emit_byte(CH_SPACE);
               phase = P_VALUE;
               return 1'b1;
            end
            P_AFTER: begin
               if (is_blank(c)) return 1'b1;
               if (depth == 0) return trip(ST_TRAILING, here);
               obj = top_obj();
               if (c == ",") begin
                  emit_byte(c);
                  break_line(depth);
                  phase = obj ? P_KEY : P_VALUE;
                  return 1'b1;
               end
               if (c == (obj ? "}" : "]")) begin
                  break_line(depth - 1);
                  emit_byte(c);
                  depth--;
                  return 1'b1;
               end
               return trip(obj ? ST_EXP_OBJSEP : ST_EXP_ARRSEP, here);
            end
            P_STR: begin
               if (c == "\"") begin
                  emit_byte(c);
                  phase = (lit_sel == 1) ? P_COLON : P_AFTER;
                  return 1'b1;
               end
               // A control character is reported one past its own index.
               if (c < 8'h20) return trip(ST_CTRL_CHAR, here + 1);
               emit_byte(c);
               if (c == "\\") phase = P_ESC;
               return 1'b1;
            end
            P_ESC: begin
               if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                   c == "n" || c == "r" || c == "t") begin
                  emit_byte(c);
                  phase = P_STR;
                  return 1'b1;
               end
               if (c == "u") begin
                  emit_byte(c);
                  tok_pos = 0;
                  phase = P_HEX;
                  return 1'b1;
               end
               return trip(ST_BAD_ESC, here + 1);
            end
            P_HEX: begin
               if (!(is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
                  return trip(ST_BAD_UESC, here);
               emit_byte(c);
               tok_pos++;
               if (tok_pos >= 4) phase = P_STR;
               return 1'b1;
            end
            P_NSIGN: begin
               if (!is_num(c)) return trip(ST_BAD_NUM, here);
               emit_byte(c);
               phase = (c == "0") ? P_NZERO : P_NINT;
               return 1'b1;
            end
            P_NZERO, P_NINT, P_NFRAC: begin
               if (is_num(c) && phase != P_NZERO) begin
                  emit_byte(c);
                  return 1'b1;
               end
               if (c == "." && phase != P_NFRAC) begin
                  emit_byte(c);
                  phase = P_NDOT;
                  return 1'b1;
               end
               if (c == "e" || c == "E") begin
                  emit_byte(c);
                  phase = P_NEXP;
                  return 1'b1;
               end
               // The number ends here; the byte is parsed again after it.
               phase = P_AFTER;
            end
            P_NDOT: begin
               if (!is_num(c)) return trip(ST_BAD_FRAC, here);
               emit_byte(c);
               phase = P_NFRAC;
               return 1'b1;
            end
            P_NEXP: begin
               if (c == "+" || c == "-") begin
                  emit_byte(c);
                  phase = P_NESIGN;
                  return 1'b1;
               end
               if (!is_num(c)) return trip(ST_BAD_EXP, here);
               emit_byte(c);
               phase = P_NEDIG;
               return 1'b1;
            end
            P_NESIGN: begin
               if (!is_num(c)) return trip(ST_BAD_EXP, here);
               emit_byte(c);
               phase = P_NEDIG;
               return 1'b1;
            end
            P_NEDIG: begin
               if (is_num(c)) begin
                  emit_byte(c);
                  return 1'b1;
               end
               phase = P_AFTER;
            end
            P_LIT: begin
               if (tok_pos < spell[lit_sel].len() && c == spell[lit_sel][tok_pos]) begin
                  emit_byte(c);
                  tok_pos++;
                  if (tok_pos >= spell[lit_sel].len()) phase = P_AFTER;
                  return 1'b1;
               end
               // A bad literal is reported at its first byte.
               return trip(ST_BAD_LIT, (here >= tok_pos) ? here - tok_pos : 0);
            end
            default: return 1'b0;
         endcase
      end
   endfunction

   // Status word of an end mark, worked out from where the parser stopped.
   function automatic word_t end_status();
      word_t w;
      w = '{8'h00, 1'b0, ST_VALID, POS_W'(text_len), 1'b1};
      case (phase)
         P_VALUE: w.status = ST_EXP_VALUE;
         P_KEY: w.status = ST_EXP_STRING;
         P_COLON: w.status = ST_EXP_COLON;
         P_STR: w.status = ST_OPEN_STR;
         P_ESC: w.status = ST_OPEN_ESC;
         P_HEX: w.status = ST_BAD_UESC;
         P_NSIGN: w.status = ST_BAD_NUM;
         P_NDOT: w.status = ST_BAD_FRAC;
         P_NEXP, P_NESIGN: w.status = ST_BAD_EXP;
         P_LIT: begin
            w.status = ST_BAD_LIT;
            w.position = POS_W'((text_len >= tok_pos) ? text_len - tok_pos : 0);
         end
         P_ERR: w.status = err_code;
         default: w.status = (depth == 0) ? ST_VALID : top_obj() ? ST_EXP_OBJSEP : ST_EXP_ARRSEP;
      endcase
      return w;
   endfunction

   // Predicts the words one accepted input word causes and queues them.
   function automatic void predict_words(logic op, logic [7:0] c);
      word_t w;
      if (op == OP_END) begin
         w = end_status();
         pending_words = {pending_words, w};
         clear_parser();
         return;
      end
      if (phase == P_ERR) return;
      emitted.delete();
      if (!parse_byte(c)) return;
      if (text_len < CNT_MAX) text_len++;
      foreach (emitted[k]) begin
         w = '{emitted[k], 1'b1, ST_VALID, '0, k == emitted.size() - 1};
         pending_words = {pending_words, w};
      end
   endfunction

   // Result side: check every accepted word against the oldest prediction.
   always @(negedge clock) begin
      word_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_words.size() == 0) begin
            report("unexpected word, out_byte", rsp_out_byte, -1);
         end else begin
            want = pending_words.pop_front();
            if (rsp_out_byte !== want.out_byte) report("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_has_byte !== want.has_byte) report("has_byte", rsp_has_byte, want.has_byte);
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
            if (rsp_error_position !== want.position)
               report("error_position", rsp_error_position, want.position);
            if (rsp_run_end !== want.run_end) report("run_end", rsp_run_end, want.run_end);
         end
      end
   end

   // Receiver stalls come in bursts so that they land on every output phase.
   int pop_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         pop_hold <= $urandom_range(1, 19) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Offers one input word, with an occasional idle burst in front of it,
   // and returns at the edge that took it.
   task automatic send_word(input logic op, input logic [7:0] c);
      bit taken;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_in_byte <= c;
      do begin
         @(negedge clock);
         taken = !req_full;
         @(posedge clock);
      end while (!taken);
      predict_words(op, c);
   endtask

   // Holds the sender until every predicted word has come out, then lets the
   // block settle, since a failed byte gives no word to wait for.
   task automatic drain();
      req_push <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      drain();
      csr_write <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      mode_q = m;
   endtask

   task automatic add_blanks();
      logic [7:0] pick[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) doc_add(pick[$urandom_range(0, 3)]);
   endtask

   task automatic add_string();
      logic [7:0] esc[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
      logic [7:0] hexd[6] = '{"0", "9", "a", "F", "c", "E"};
      int kind;
      doc_add("\"");
      repeat ($urandom_range(0, 4)) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            doc_add("\\");
            doc_add(esc[$urandom_range(0, 7)]);
         end else if (kind == 1) begin
            doc_add("\\");
            doc_add("u");
            repeat (4) doc_add(hexd[$urandom_range(0, 5)]);
         end else if (kind == 2) begin
            doc_add(8'($urandom_range(8'h80, 8'hFF)));
         end else begin
            doc_add(8'($urandom_range("a", "z")));
         end
      end
      doc_add("\"");
   endtask

   task automatic add_number();
      if ($urandom_range(0, 2) == 0) doc_add("-");
      if ($urandom_range(0, 3) == 0) doc_add("0");
      else repeat ($urandom_range(1, 3)) doc_add(8'($urandom_range("1", "9")));
      if ($urandom_range(0, 2) == 0) begin
         doc_add(".");
         repeat ($urandom_range(1, 2)) doc_add(8'($urandom_range("0", "9")));
      end
      if ($urandom_range(0, 3) == 0) begin
         doc_add($urandom_range(0, 1) ? "e" : "E");
         case ($urandom_range(0, 2))
            0: doc_add("+");
            1: doc_add("-");
            default: ;
         endcase
         doc_add(8'($urandom_range("0", "9")));
      end
   endtask

   // Appends one well-formed value; containers get fewer members deeper down.
   task automatic add_value(input int lvl);
      int pick;
      int count;
      string word;
      pick = $urandom_range(0, 9);
      if (lvl >= 3 && pick < 4) pick = pick + 4;
      add_blanks();
      case (pick)
         0, 1: begin
            doc_add("{");
            count = $urandom_range(0, 3 - lvl / 2);
            for (int i = 0; i < count; i++) begin
               if (i > 0) doc_add(",");
               add_blanks();
               add_string();
               add_blanks();
               doc_add(":");
               add_value(lvl + 1);
            end
            add_blanks();
            doc_add("}");
         end
         2, 3: begin
            doc_add("[");
            count = $urandom_range(0, 3 - lvl / 2);
            for (int i = 0; i < count; i++) begin
               if (i > 0) doc_add(",");
               add_value(lvl + 1);
            end
            add_blanks();
            doc_add("]");
         end
         4, 5: add_string();
         6, 7: add_number();
         default: begin
            word = spell[$urandom_range(0, 2)];
            for (int i = 0; i < word.len(); i++) doc_add(word[i]);
         end
      endcase
      add_blanks();
   endtask

   // Directed table: reset state, a short valid document, extremes of the
   // byte, a control character, a bad literal, and a small object.
   row_t plan[] = '{
      '{OP_END,  8'h00, 1'b1, ST_EXP_VALUE, 0},
      '{OP_BYTE, "[",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "1",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "]",   1'b0, ST_VALID, 0},
      '{OP_END,  8'hFF, 1'b1, ST_VALID, 3},
      '{OP_BYTE, 8'hFF, 1'b0, ST_VALID, 0},
      '{OP_END,  8'h00, 1'b1, ST_EXP_VALUE, 0},
      '{OP_BYTE, "\"",  1'b0, ST_VALID, 0},
      '{OP_BYTE, 8'h01, 1'b0, ST_VALID, 0},
      '{OP_END,  8'h00, 1'b1, ST_CTRL_CHAR, 2},
      '{OP_BYTE, "t",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "x",   1'b0, ST_VALID, 0},
      '{OP_END,  8'h00, 1'b1, ST_BAD_LIT, 0},
      '{OP_BYTE, "{",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "\"",  1'b0, ST_VALID, 0},
      '{OP_BYTE, "a",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "\"",  1'b0, ST_VALID, 0},
      '{OP_BYTE, ":",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "n",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "u",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "l",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "l",   1'b0, ST_VALID, 0},
      '{OP_BYTE, "}",   1'b0, ST_VALID, 0},
      '{OP_END,  8'h00, 1'b1, ST_VALID, 10}
   };

   initial begin
      int sent;
      int docs;
      int cut;
      word_t typed_word;
      reset = 1'b1;
      req_push = 1'b0;
      req_op = OP_BYTE;
      req_in_byte = 8'h00;
      csr_write = 1'b0;
      csr_data = MODE_TWO;
      mode_q = MODE_TWO;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: typed rows replace the predicted status word with the
      // value written in the table.
      foreach (plan[r]) begin
         send_word(plan[r].op, plan[r].text);
         if (plan[r].typed) begin
            typed_word = '{8'h00, 1'b0, plan[r].status, POS_W'(plan[r].position), 1'b1};
            pending_words[pending_words.size() - 1] = typed_word;
         end
      end

      // Random part: mostly well-formed documents, some damaged, in each mode.
      sent = 0;
      docs = 0;
      while (sent < RUN_ITEMS) begin
         if (docs % 4 == 0) set_mode(2'((docs < 16) ? docs / 4 : $urandom_range(0, 3)));
         if (sent > RUN_ITEMS - QUIET_TAIL) quiet = 1;
         doc.delete();
         add_value(0);
         case ($urandom_range(0, 9))
            0: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
               cut = $urandom_range(0, doc.size() - 1);
               while (doc.size() > cut) void'(doc.pop_back());
            end
            2: begin
               // Nesting one level past the limit.
               doc.delete();
               repeat (MAX_LEVELS + 1) doc_add($urandom_range(0, 1) ? "[" : "{");
            end
            3: repeat ($urandom_range(1, 3)) doc_add(8'($urandom_range(0, 255)));
            default: ;
         endcase
         foreach (doc[i]) send_word(OP_BYTE, doc[i]);
         send_word(OP_END, 8'($urandom_range(0, 255)));
         sent += doc.size() + 1;
         docs++;
      end

      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
